### design/spgb_pkg.sv
package spgb_pkg;

    localparam int RotW = 52;
    localparam int AccW = 32;
    localparam logic signed [17:0] HalfPi = 18'sd102944;

    typedef enum logic [2:0] {
        REG_ORIGIN_AZ = 3'd0,
        REG_ORIGIN_EL = 3'd1,
        REG_CELL_WIDTH = 3'd2,
        REG_COLUMNS = 3'd3,
        REG_ROWS = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [RotW-1:0] x;
        logic signed [RotW-1:0] y;
        logic signed [AccW-1:0] acc;
    } t_rot;

    typedef struct packed {
        t_rot az;
        t_rot el;
        logic [63:0] rad;
        logic [63:0] res;
        logic signed [17:0] faz;
        logic signed [17:0] fel;
        logic zf;
    } t_cell;

    typedef struct packed {
        logic [17:0] dvd_c;
        logic [17:0] rem_c;
        logic [17:0] q_c;
        logic [17:0] dvd_r;
        logic [17:0] rem_r;
        logic [17:0] q_r;
        logic signed [17:0] az;
        logic signed [17:0] el;
        logic [31:0] radial;
        logic zf;
    } t_div;

    // atan(2^-i) in Q2.30
    function automatic logic signed [AccW-1:0] atan_q30(input int i);
        logic signed [AccW-1:0] v;
        case (i)
            0: v = 32'sd843314857;
            1: v = 32'sd497837829;
            2: v = 32'sd263043837;
            3: v = 32'sd133525159;
            4: v = 32'sd67021687;
            5: v = 32'sd33543516;
            6: v = 32'sd16775851;
            7: v = 32'sd8388437;
            8: v = 32'sd4194283;
            9: v = 32'sd2097149;
            10: v = 32'sd1048576;
            default: v = (i <= 30) ? (32'sd1 <<< (30 - i)) : 32'sd0;
        endcase
        return v;
    endfunction

    function automatic t_rot rot_step(input t_rot a, input int sh);
        t_rot r;
        logic signed [RotW-1:0] xs;
        logic signed [RotW-1:0] ys;
        xs = a.x >>> sh;
        ys = a.y >>> sh;
        r = a;
        if (!a.y[RotW-1]) begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.acc = a.acc + atan_q30(sh);
        end else begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.acc = a.acc - atan_q30(sh);
        end
        return r;
    endfunction

endpackage

### design/spgb_in_if.sv
interface spgb_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source(output valid, point_x, point_y, point_z, input ready);
    modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

### design/spgb_out_if.sv
interface spgb_out_if;
    logic valid;
    logic ready;
    logic signed [17:0] azimuth;
    logic signed [17:0] elevation;
    logic [31:0] distance;
    logic [7:0] cell_col;
    logic [7:0] cell_row;
    logic [15:0] cell_index;
    logic depth_zero;
    modport source(output valid, azimuth, elevation, distance, cell_col, cell_row,
        cell_index, depth_zero, input ready);
    modport sink(input valid, azimuth, elevation, distance, cell_col, cell_row,
        cell_index, depth_zero, output ready);
endinterface

### design/spgb_cfg_if.sv
interface spgb_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [17:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### design/spherical_projection_grid_binner.sv
// Projects a Q16.16 point to azimuth/elevation (vectoring CORDIC) and distance
// (restoring square root), then bins the angles on a rectangular grid. Items move
// through a row of 32 cells, each doing one root digit and, for cell indices
// below CORDIC_STEPS, one CORDIC rotation on both angles, then through 18
// restoring-divider cells that divide by cell_width. One word per cycle is taken
// while the row advances: whenever the output register is empty or being taken.
// Write configuration only while no words are in flight.
module spherical_projection_grid_binner #(
    parameter int GRID_DIM = 256,
    parameter int CORDIC_STEPS = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spgb_in_if.sink i_pt,
    spgb_cfg_if.sink i_cfg,
    spgb_out_if.source o_res
);
    import spgb_pkg::*;

    localparam int NCells = 32;
    localparam int NDiv = 18;

    logic signed [17:0] r_org_az, r_org_el;
    logic [17:0] r_width;
    logic [8:0] r_cols, r_rows;

    logic w_adv;
    logic w_cv [0:NCells];
    t_cell w_c [0:NCells];
    logic w_dv [0:NDiv];
    t_div w_dd [0:NDiv];
    t_div n_f;
    logic r_fv;
    t_div r_fd;
    logic signed [18:0] w_raz, w_rel, w_caz, w_cel, w_daz, w_del;
    logic [8:0] w_lim_c, w_lim_r;
    logic r_sv;
    logic [8:0] r_col, r_row;
    t_div r_s;
    logic r_ov;
    logic [17:0] w_idx;

    function automatic logic [8:0] lim_of(input logic [8:0] n);
        if (n == '0) begin
            return 9'd0;
        end else if (int'(n) > GRID_DIM) begin
            return 9'(GRID_DIM - 1);
        end else begin
            return n - 9'd1;
        end
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_az <= '0;
            r_org_el <= '0;
            r_width <= 18'd65536;
            r_cols <= 9'd256;
            r_rows <= 9'd256;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_ORIGIN_AZ: r_org_az <= i_cfg.data;
                REG_ORIGIN_EL: r_org_el <= i_cfg.data;
                REG_CELL_WIDTH: r_width <= i_cfg.data;
                REG_COLUMNS: r_cols <= i_cfg.data[8:0];
                REG_ROWS: r_rows <= i_cfg.data[8:0];
                default: ;
            endcase
        end
    end

    assign w_adv = !r_ov || o_res.ready;
    assign i_pt.ready = w_adv;

    spgb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(i_pt.valid),
        .i_x(i_pt.point_x), .i_y(i_pt.point_y), .i_z(i_pt.point_z),
        .o_valid(w_cv[0]), .o_d(w_c[0])
    );

    for (genvar g = 0; g < NCells; g++) begin : g_cell
        spgb_cell #(.Idx(g), .Steps(CORDIC_STEPS)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(w_cv[g]),
            .i_d(w_c[g]), .o_valid(w_cv[g+1]), .o_d(w_c[g+1])
        );
    end

    // round Q30 to Q16, clamp, force on zero depth, offset by origin
    always_comb begin
        w_raz = 19'((33'(w_c[NCells].az.acc) + 33'sd8192) >>> 14);
        w_rel = 19'((33'(w_c[NCells].el.acc) + 33'sd8192) >>> 14);
        w_caz = (w_raz > 19'(HalfPi)) ? 19'(HalfPi)
              : ((w_raz < -19'(HalfPi)) ? -19'(HalfPi) : w_raz);
        w_cel = (w_rel > 19'(HalfPi)) ? 19'(HalfPi)
              : ((w_rel < -19'(HalfPi)) ? -19'(HalfPi) : w_rel);
        if (w_c[NCells].zf) begin
            w_caz = 19'(w_c[NCells].faz);
            w_cel = 19'(w_c[NCells].fel);
        end
        w_daz = w_caz - 19'(r_org_az);
        w_del = w_cel - 19'(r_org_el);
        n_f = '0;
        n_f.az = w_caz[17:0];
        n_f.el = w_cel[17:0];
        n_f.radial = w_c[NCells].res[31:0];
        n_f.zf = w_c[NCells].zf;
        n_f.dvd_c = w_daz[18] ? 18'd0 : w_daz[17:0];
        n_f.dvd_r = w_del[18] ? 18'd0 : w_del[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_adv) begin
            r_fv <= w_cv[NCells];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fd <= n_f;
        end
    end

    assign w_dv[0] = r_fv;
    assign w_dd[0] = r_fd;

    for (genvar g = 0; g < NDiv; g++) begin : g_div
        spgb_div_cell u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_adv), .i_valid(w_dv[g]),
            .i_width(r_width), .i_d(w_dd[g]), .o_valid(w_dv[g+1]), .o_d(w_dd[g+1])
        );
    end

    assign w_lim_c = lim_of(r_cols);
    assign w_lim_r = lim_of(r_rows);

    // saturate the quotients, then form the flat index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_sv <= w_dv[NDiv];
            r_ov <= r_sv;
        end
    end

    assign w_idx = 18'(r_col) * (18'(w_lim_r) + 18'd1) + 18'(r_row);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s <= w_dd[NDiv];
            r_col <= (w_dd[NDiv].q_c > 18'(w_lim_c)) ? w_lim_c : w_dd[NDiv].q_c[8:0];
            r_row <= (w_dd[NDiv].q_r > 18'(w_lim_r)) ? w_lim_r : w_dd[NDiv].q_r[8:0];
            o_res.azimuth <= r_s.az;
            o_res.elevation <= r_s.el;
            o_res.distance <= r_s.radial;
            o_res.cell_col <= r_col[7:0];
            o_res.cell_row <= r_row[7:0];
            o_res.cell_index <= w_idx[15:0];
            o_res.depth_zero <= r_s.zf;
        end
    end

    assign o_res.valid = r_ov;

    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.azimuth <= HalfPi && o_res.azimuth >= -HalfPi))
        else $error("azimuth out of range");
    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.depth_zero) |-> (o_res.elevation == HalfPi ||
        o_res.elevation == -HalfPi || o_res.elevation == 18'sd0))
        else $error("zero depth elevation not forced");
    a_col_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> (r_col <= w_lim_c && r_row <= w_lim_r))
        else $error("cell coordinate beyond grid");
endmodule

### design/spgb_front.sv
module spgb_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    output logic o_valid,
    output spgb_pkg::t_cell o_d
);
    import spgb_pkg::*;

    logic r_va, r_vb;
    logic [63:0] r_sqx, r_sqy, r_sqz;
    t_cell r_a, n_a, r_b, n_b;
    logic signed [32:0] w_zabs, w_nx, w_ny;

    always_comb begin
        w_zabs = i_z[31] ? -33'(i_z) : 33'(i_z);
        w_nx = i_z[31] ? -33'(i_x) : 33'(i_x);
        w_ny = i_z[31] ? -33'(i_y) : 33'(i_y);
        n_a = '0;
        n_a.az.x = RotW'(w_zabs) <<< 16;
        n_a.az.y = RotW'(w_nx) <<< 16;
        n_a.el.x = RotW'(w_zabs) <<< 16;
        n_a.el.y = RotW'(w_ny) <<< 16;
        n_a.faz = (i_x == '0) ? 18'sd0 : (i_x[31] ? -HalfPi : HalfPi);
        n_a.fel = (i_y == '0) ? 18'sd0 : (i_y[31] ? -HalfPi : HalfPi);
        n_a.zf = (i_z == '0);
    end

    always_comb begin
        n_b = r_a;
        n_b.rad = r_sqx + r_sqy + r_sqz;
        n_b.res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx <= 64'(i_x) * 64'(i_x);
            r_sqy <= 64'(i_y) * 64'(i_y);
            r_sqz <= 64'(i_z) * 64'(i_z);
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_valid = r_vb;
    assign o_d = r_b;
endmodule

### design/spgb_cell.sv
module spgb_cell #(
    parameter int Idx = 0,
    parameter int Steps = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  spgb_pkg::t_cell i_d,
    output logic o_valid,
    output spgb_pkg::t_cell o_d
);
    import spgb_pkg::*;

    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * Idx);

    t_cell n_d, r_d;
    logic r_v;
    logic [63:0] w_trial;

    always_comb begin
        n_d = i_d;
        if (Idx < Steps) begin
            n_d.az = rot_step(i_d.az, Idx);
            n_d.el = rot_step(i_d.el, Idx);
        end
        w_trial = i_d.res + Bit;
        if (i_d.rad >= w_trial) begin
            n_d.rad = i_d.rad - w_trial;
            n_d.res = (i_d.res >> 1) + Bit;
        end else begin
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_d = r_d;
endmodule

### design/spgb_div_cell.sv
module spgb_div_cell (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  logic [17:0] i_width,
    input  spgb_pkg::t_div i_d,
    output logic o_valid,
    output spgb_pkg::t_div o_d
);
    import spgb_pkg::*;

    t_div n_d, r_d;
    logic r_v;
    logic [18:0] w_pc, w_pr;

    // one restoring quotient bit per lane
    always_comb begin
        n_d = i_d;
        w_pc = {i_d.rem_c, i_d.dvd_c[17]};
        w_pr = {i_d.rem_r, i_d.dvd_r[17]};
        n_d.dvd_c = i_d.dvd_c << 1;
        n_d.dvd_r = i_d.dvd_r << 1;
        if (w_pc >= {1'b0, i_width}) begin
            n_d.rem_c = 18'(w_pc - {1'b0, i_width});
            n_d.q_c = {i_d.q_c[16:0], 1'b1};
        end else begin
            n_d.rem_c = w_pc[17:0];
            n_d.q_c = {i_d.q_c[16:0], 1'b0};
        end
        if (w_pr >= {1'b0, i_width}) begin
            n_d.rem_r = 18'(w_pr - {1'b0, i_width});
            n_d.q_r = {i_d.q_r[16:0], 1'b1};
        end else begin
            n_d.rem_r = w_pr[17:0];
            n_d.q_r = {i_d.q_r[16:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_v;
    assign o_d = r_d;
endmodule

### sim/tb_spherical_projection_grid_binner.sv
module tb_spherical_projection_grid_binner;
    import spgb_pkg::*;

    localparam int GridDim = 256;
    localparam int CordicSteps = 20;
    localparam longint HalfPiQ16 = 102944;
    localparam int DrainCycles = 70;
    localparam logic [2:0] RegUnused = 3'd7;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef struct {
        logic signed [17:0] azimuth;
        logic signed [17:0] elevation;
        logic [31:0] distance;
        logic [7:0] cell_col;
        logic [7:0] cell_row;
        logic [15:0] cell_index;
        logic depth_zero;
    } bin_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    spgb_in_if pt ();
    spgb_cfg_if cfg ();
    spgb_out_if res ();

    spherical_projection_grid_binner #(
        .GRID_DIM(GridDim),
        .CORDIC_STEPS(CordicSteps)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pt(pt.sink),
        .i_cfg(cfg.sink),
        .o_res(res.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow of the grid registers
    logic signed [17:0] grid_org_az = 18'sd0;
    logic signed [17:0] grid_org_el = 18'sd0;
    logic [17:0] grid_cell_w = 18'd65536;
    logic [8:0] grid_cols = 9'd256;
    logic [8:0] grid_rows = 9'd256;

    point_t pending_points[$];
    bin_t expected_bins[$];
    int fails = 0;
    bit idle_ok = 1'b1;
    int hold_req = 0;

    function automatic longint arctan_q30(input int i);
        case (i)
            0: return 843314857;
            1: return 497837829;
            2: return 263043837;
            3: return 133525159;
            4: return 67021687;
            5: return 33543516;
            6: return 16775851;
            7: return 8388437;
            8: return 4194283;
            9: return 2097149;
            10: return 1048576;
            default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 0;
        endcase
    endfunction

    function automatic longint angle_q16(input longint num, input longint den);
        longint x, y, acc, xs, ys;
        if (den == 0)
            return (num > 0) ? HalfPiQ16 : ((num < 0) ? -HalfPiQ16 : 0);
        x = ((den < 0) ? -den : den) * 65536;
        y = ((den < 0) ? -num : num) * 65536;
        acc = 0;
        for (int i = 0; i < CordicSteps; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + arctan_q30(i);
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - arctan_q30(i);
            end
        end
        acc = (acc + 8192) >>> 14;
        if (acc > HalfPiQ16) acc = HalfPiQ16;
        if (acc < -HalfPiQ16) acc = -HalfPiQ16;
        return acc;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int used_cells(input logic [8:0] n);
        if (n == 0) return 1;
        if (n > GridDim) return GridDim;
        return n;
    endfunction

    function automatic int grid_coord(input longint angle, input longint org, input int cells);
        longint d;
        longint unsigned q;
        d = angle - org;
        if (d < 0) d = 0;
        if (grid_cell_w == 0) q = '1;
        else q = longint'(d) / longint'(grid_cell_w);
        if (q > cells - 1) q = cells - 1;
        return int'(q);
    endfunction

    function automatic bin_t bin_point(input point_t p);
        bin_t b;
        longint px, py, pz, az, el;
        longint unsigned sq;
        int cols, rows, col, row;
        px = p.x;
        py = p.y;
        pz = p.z;
        az = angle_q16(px, pz);
        el = angle_q16(py, pz);
        sq = longint'(px * px) + longint'(py * py) + longint'(pz * pz);
        cols = used_cells(grid_cols);
        rows = used_cells(grid_rows);
        col = grid_coord(az, grid_org_az, cols);
        row = grid_coord(el, grid_org_el, rows);
        b.azimuth = az[17:0];
        b.elevation = el[17:0];
        b.distance = 32'(root_floor(sq));
        b.cell_col = col[7:0];
        b.cell_row = row[7:0];
        b.cell_index = 16'(col * rows + row);
        b.depth_zero = (pz == 0);
        return b;
    endfunction

    // point driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt.valid <= 1'b0;
        end else begin
            if (pt.valid && pt.ready)
                expected_bins = {expected_bins,
                    bin_point('{pt.point_x, pt.point_y, pt.point_z})};
            if (!pt.valid || pt.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    pt.valid <= 1'b0;
                end else if (idle_ok && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 6);
                    pt.valid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    point_t p;
                    p = pending_points.pop_front();
                    pt.point_x <= p.x;
                    pt.point_y <= p.y;
                    pt.point_z <= p.z;
                    pt.valid <= 1'b1;
                end else begin
                    pt.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                if (expected_bins.size() == 0) begin
                    $display("%0t: unexpected word az=%0d el=%0d", $time,
                        res.azimuth, res.elevation);
                    fails++;
                end else begin
                    bin_t e;
                    e = expected_bins.pop_front();
                    if (res.azimuth !== e.azimuth || res.elevation !== e.elevation ||
                        res.distance !== e.distance || res.cell_col !== e.cell_col ||
                        res.cell_row !== e.cell_row || res.cell_index !== e.cell_index ||
                        res.depth_zero !== e.depth_zero) begin
                        $display("%0t: expected az=%0d el=%0d d=%0d c=%0d r=%0d i=%0d z=%0d",
                            $time, e.azimuth, e.elevation, e.distance, e.cell_col,
                            e.cell_row, e.cell_index, e.depth_zero);
                        $display("%0t: actual   az=%0d el=%0d d=%0d c=%0d r=%0d i=%0d z=%0d",
                            $time, res.azimuth, res.elevation, res.distance, res.cell_col,
                            res.cell_row, res.cell_index, res.depth_zero);
                        fails++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen <= hold_req;
                hold_left <= 300;
                res.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                res.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                res.ready <= 1'b0;
            end else if (idle_ok && $urandom_range(0, 9) == 0) begin
                stall_left <= $urandom_range(0, 6);
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        @(posedge i_clk);
        cfg.index <= idx;
        cfg.data <= val;
        cfg.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            REG_ORIGIN_AZ: grid_org_az = val;
            REG_ORIGIN_EL: grid_org_el = val;
            REG_CELL_WIDTH: grid_cell_w = val;
            REG_COLUMNS: grid_cols = val[8:0];
            REG_ROWS: grid_rows = val[8:0];
            default: ;
        endcase
        cfg.valid <= 1'b0;
    endtask

    task automatic set_grid(input int oaz, input int oel, input int cw, input int nc,
                            input int nr);
        write_reg(REG_ORIGIN_AZ, oaz[17:0]);
        write_reg(REG_ORIGIN_EL, oel[17:0]);
        write_reg(REG_CELL_WIDTH, cw[17:0]);
        write_reg(REG_COLUMNS, nc[17:0]);
        write_reg(REG_ROWS, nr[17:0]);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_points.size() > 0 || pt.valid || expected_bins.size() > 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64;
            2: return $signed($urandom_range(0, 2 * 65536)) - 65536;
            3: return $signed($urandom_range(0, 32)) - 16;
            4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 2 * 65536 * 4096)) - 65536 * 4096;
        endcase
    endfunction

    task automatic queue_random(input int n);
        point_t p;
        repeat (n) begin
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = ($urandom_range(0, 11) == 0) ? 32'sd0 : rand_coord();
            pending_points = {pending_points, p};
        end
    endtask

    task automatic queue_point(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] z);
        point_t p;
        p = '{x, y, z};
        pending_points = {pending_points, p};
    endtask

    initial begin
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.point_z = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        res.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero depth, points on each axis
        queue_point(0, 0, 0);
        queue_point(65536, 0, 0);
        queue_point(-65536, 0, 0);
        queue_point(0, 65536, 0);
        queue_point(0, -65536, 0);
        queue_point(65536, -65536, 0);
        queue_point(0, 0, 65536);
        queue_point(0, 0, -65536);
        queue_point(65536, 65536, 65536);
        queue_point(-65536, -65536, 65536);
        queue_point(65536, 65536, -65536);
        queue_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        queue_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_point(32'sh7fffffff, 32'sh80000000, 1);
        queue_point(32'sh80000000, 32'sh7fffffff, -1);
        queue_point(1, -1, 32'sh7fffffff);
        queue_point(-1, 1, 32'sh80000000);
        queue_point(32'shffffffff, 32'shffffffff, 32'shffffffff);
        queue_point(32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff);
        queue_point(32'shaaaaaaaa, 32'sh55555555, 32'shffff0000);
        queue_random(100);
        wait_drained();

        // fine grid, negative origins; receiver holds off to fill the pipe
        set_grid(-102944, -102944, 805, 256, 256);
        hold_req++;
        queue_random(140);
        wait_drained();

        // single cell, unused index must change nothing
        set_grid(102944, 102944, 1, 1, 1);
        write_reg(RegUnused, 18'h3ffff);
        queue_random(110);
        wait_drained();

        // zero width and zero counts, oversize counts
        set_grid(0, -50000, 0, 0, 511);
        queue_random(100);
        wait_drained();
        set_grid(-30000, 20000, 0, 300, 0);
        queue_random(80);
        wait_drained();

        // widest cell, odd grid shape
        set_grid(-102944, 102944, 262143, 37, 200);
        queue_random(100);
        wait_drained();

        // random grid settings
        repeat (2) begin
            set_grid($signed($urandom_range(0, 205888)) - 102944,
                     $signed($urandom_range(0, 205888)) - 102944,
                     $urandom_range(1, 4000), $urandom_range(1, 256),
                     $urandom_range(1, 256));
            queue_random(50);
            wait_drained();
        end

        // last stretch at full rate
        set_grid(-60000, -60000, 500, 256, 256);
        idle_ok = 1'b0;
        queue_random(100);
        wait_drained();

        if (fails == 0 && expected_bins.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #400000;
        $display("FAILURE");
        $finish;
    end

endmodule
